// ===== hdl/sgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgcd_pkg: shared types for the signed gcd pipeline
// Stage record carried between the gcd pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none
package sgcd_pkg;
    typedef struct packed {
        logic valid;
        logic zero_err;
    } sgcd_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/sgcd_stage.sv =====
// ----------------------------------------------------------------------------
// sgcd_stage: one binary gcd step
// Holds one operand pair and applies one binary gcd step to it per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module sgcd_stage #(
    parameter int W  = 32,
    parameter int SW = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire sgcd_pkg::sgcd_ctl_t  ctl_in,
    input  wire logic [W-1:0]         a_in,
    input  wire logic [W-1:0]         b_in,
    input  wire logic [SW-1:0]        k_in,
    output sgcd_pkg::sgcd_ctl_t       ctl_out,
    output logic      [W-1:0]         a_out,
    output logic      [W-1:0]         b_out,
    output logic      [SW-1:0]        k_out
);
    import sgcd_pkg::*;

    sgcd_ctl_t     ctl_reg;
    logic [W-1:0]  a_reg, b_reg, a_next, b_next;
    logic [SW-1:0] k_reg, k_next;

    // a holds the running value (odd once both are nonzero), b shrinks to zero
    always_comb
    begin
        a_next = a_in;
        b_next = b_in;
        k_next = k_in;
        if (b_in != '0)
        begin
            if (!a_in[0] && !b_in[0])
            begin
                a_next = a_in >> 1;
                b_next = b_in >> 1;
                k_next = k_in + SW'(1);
            end
            else if (!a_in[0])
                a_next = a_in >> 1;
            else if (!b_in[0])
                b_next = b_in >> 1;
            else if (a_in > b_in)
            begin
                a_next = b_in;
                b_next = (a_in - b_in) >> 1;
            end
            else
                b_next = (b_in - a_in) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign k_out   = k_reg;
endmodule
`default_nettype wire

// ===== hdl/signed_gcd_unit.sv =====
// ----------------------------------------------------------------------------
// signed_gcd_unit: gcd of two signed operand magnitudes
// An item passes through an input register, a chain of binary gcd stages of
// one step each (enough for any operand pair) and an output register;
// one item enters per cycle when the output is not stalled. A zero operand
// gives divisor 0 with zero_operand_error set.
// ----------------------------------------------------------------------------
`default_nettype none
module signed_gcd_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [DATA_WIDTH-1:0] first_value,
    input  wire logic [DATA_WIDTH-1:0] second_value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [DATA_WIDTH-1:0] divisor,
    output logic                       zero_operand_error
);
    import sgcd_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int SW = $clog2(W + 1);
    localparam int NS = 2 * W;

    sgcd_ctl_t     ctl [NS+1];
    logic [W-1:0]  av  [NS+1];
    logic [W-1:0]  bv  [NS+1];
    logic [SW-1:0] kv  [NS+1];

    logic          advance;
    logic          in_valid_reg;
    logic [W-1:0]  ma_reg, mb_reg;
    logic [W-1:0]  mag_a, mag_b;
    logic          out_valid_reg, out_err_reg;
    logic [W-1:0]  out_div_reg, div_next;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    assign mag_a = first_value[W-1]  ? (~first_value + W'(1))  : first_value;
    assign mag_b = second_value[W-1] ? (~second_value + W'(1)) : second_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ma_reg <= mag_a;
            mb_reg <= mag_b;
        end
    end

    assign ctl[0] = '{valid: in_valid_reg,
                      zero_err: (ma_reg == '0) || (mb_reg == '0)};
    assign av[0]  = ma_reg;
    assign bv[0]  = mb_reg;
    assign kv[0]  = '0;

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        sgcd_stage #(.W(W), .SW(SW)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl[i]),
            .a_in    (av[i]),
            .b_in    (bv[i]),
            .k_in    (kv[i]),
            .ctl_out (ctl[i+1]),
            .a_out   (av[i+1]),
            .b_out   (bv[i+1]),
            .k_out   (kv[i+1])
        );
    end

    assign div_next = ctl[NS].zero_err ? '0 : (av[NS] << kv[NS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= ctl[NS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_div_reg <= div_next;
            out_err_reg <= ctl[NS].zero_err;
        end
    end

    assign out_valid          = out_valid_reg;
    assign divisor            = out_div_reg;
    assign zero_operand_error = out_err_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(divisor))
        else $error("result changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_operand_error |-> divisor == '0)
        else $error("error result not zero");
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_operand_error |-> divisor != '0)
        else $error("zero divisor without error");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: signed gcd unit regression
// Drives signed operand pairs through the valid/stall handshake with random
// bursts and output stalls, predicts each divisor and zero-operand flag, and
// compares every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    localparam int W = 32;
    localparam int N_RAND = 1700;
    localparam int LATENCY = 2 * W + 2;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           known;
        logic [W-1:0] gcd;
        logic         err;
    } gcd_row_t;

    typedef struct {
        logic [W-1:0] gcd;
        logic         err;
    } gcd_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [W-1:0] first_value;
    logic [W-1:0] second_value;
    logic out_valid;
    logic out_stall;
    logic [W-1:0] divisor;
    logic zero_operand_error;

    gcd_result_t pending_gcds[$];
    int errors;
    int sent;
    int received;
    int zero_cases;
    longint cycles;
    bit hold_off_done;

    signed_gcd_unit #(.DATA_WIDTH(W)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .first_value(first_value),
        .second_value(second_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .divisor(divisor),
        .zero_operand_error(zero_operand_error)
    );

    function automatic logic [W-1:0] abs_of(logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic gcd_result_t predict_gcd(logic [W-1:0] a, logic [W-1:0] b);
        gcd_result_t r;
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] t;
        x = abs_of(a);
        y = abs_of(b);
        if (x == 0 || y == 0)
        begin
            r.gcd = '0;
            r.err = 1'b1;
            return r;
        end
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        r.gcd = x;
        r.err = 1'b0;
        return r;
    endfunction

    function automatic logic [W-1:0] rand_operand();
        logic [W-1:0] v;
        int sel;
        logic [W-1:0] f;
        sel = $urandom_range(0, 9);
        v = $urandom;
        f = $urandom_range(1, 5000);
        case (sel)
            0: v = v;
            1: v = f * $urandom_range(1, 400000);
            2: v = -(f * $urandom_range(1, 400000));
            3: v = 32'h1 << $urandom_range(0, 31);
            4: v = $urandom_range(0, 3) == 0 ? '0 : $urandom_range(1, 64);
            5: v = {1'b1, {(W-1){1'b0}}} + $urandom_range(0, 3);
            6: v = {1'b0, {(W-1){1'b1}}} - $urandom_range(0, 3);
            default: v = (f * 210) << $urandom_range(0, 8);
        endcase
        return v;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stall pattern plus one long hold-off
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_off_done && sent > 300)
            begin
                hold_off_done = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            n = $urandom_range(1, 20);
            case ($urandom_range(0, 3))
                0: out_stall <= 1'b0;
                1: out_stall <= 1'b1;
                default: out_stall <= ($urandom_range(0, 2) == 0);
            endcase
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        gcd_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (pending_gcds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result divisor=%h err=%b",
                    $time, divisor, zero_operand_error);
            end
            else
            begin
                exp_r = pending_gcds.pop_front();
                if (divisor !== exp_r.gcd || zero_operand_error !== exp_r.err)
                begin
                    errors++;
                    $display("%0t: mismatch expected divisor=%h err=%b actual divisor=%h err=%b",
                        $time, exp_r.gcd, exp_r.err, divisor, zero_operand_error);
                end
            end
        end
    end

    task automatic send_pair(gcd_row_t row);
        gcd_result_t p;
        p = predict_gcd(row.a, row.b);
        if (row.known && (p.gcd !== row.gcd || p.err !== row.err))
        begin
            errors++;
            $display("%0t: table row expected divisor=%h err=%b predicted divisor=%h err=%b",
                $time, row.gcd, row.err, p.gcd, p.err);
        end
        if (p.err)
            zero_cases++;
        in_valid <= 1'b1;
        first_value <= row.a;
        second_value <= row.b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_gcds.push_back(row.known ? gcd_result_t'{row.gcd, row.err} : p);
        sent++;
    endtask

    task automatic maybe_gap(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return;
        end
        burst = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    initial
    begin
        gcd_row_t dir_rows[$];
        gcd_row_t row;
        int burst;
        int wait_cycles;
        logic [W-1:0] most_neg;
        logic [W-1:0] most_pos;
        most_neg = {1'b1, {(W-1){1'b0}}};
        most_pos = {1'b0, {(W-1){1'b1}}};
        in_valid = 1'b0;
        first_value = '0;
        second_value = '0;
        errors = 0;
        sent = 0;
        received = 0;
        zero_cases = 0;
        cycles = 0;
        hold_off_done = 1'b0;
        burst = 0;

        dir_rows = '{
            '{'0, '0, 1, '0, 1'b1},
            '{'0, 32'd7, 1, '0, 1'b1},
            '{-32'sd9, '0, 1, '0, 1'b1},
            '{most_neg, '0, 1, '0, 1'b1},
            '{most_neg, most_neg, 1, most_neg, 1'b0},
            '{most_neg, 32'd1, 1, 32'd1, 1'b0},
            '{most_neg, -32'sd1024, 1, 32'd1024, 1'b0},
            '{most_pos, most_pos, 1, most_pos, 1'b0},
            '{most_pos, most_neg, 1, 32'd1, 1'b0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd1, 1'b0},
            '{32'd1, 32'd1, 1, 32'd1, 1'b0},
            '{-32'sd12, 32'd12, 1, 32'd12, 1'b0},
            '{32'd12, 32'd18, 0, '0, 1'b0},
            '{-32'sd48, -32'sd180, 0, '0, 1'b0},
            '{32'd17, 32'd5, 0, '0, 1'b0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 0, '0, 1'b0},
            '{32'd1836311903, 32'd1134903170, 0, '0, 1'b0},
            '{32'h4000_0000, 32'h0000_0400, 0, '0, 1'b0},
            '{32'd3, most_pos, 0, '0, 1'b0}
        };

        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (dir_rows[i])
            send_pair(dir_rows[i]);

        for (int i = 0; i < N_RAND; i++)
        begin
            maybe_gap(burst);
            row.a = rand_operand();
            row.b = $urandom_range(0, 3) == 0 ? row.a * $urandom_range(1, 9)
                                               : rand_operand();
            if ($urandom_range(0, 1))
                row.b = -row.b;
            row.known = 0;
            send_pair(row);
        end
        in_valid <= 1'b0;

        while (pending_gcds.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 4 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results",
            sent, zero_cases, received);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
